// ===== rtl/core/avc_nst_pkg.sv =====
`default_nettype none

package avc_nst_pkg;

    // NAL unit type codes that the tracker acts on.
    localparam logic [4:0] NAL_NON_IDR    = 5'd1;
    localparam logic [4:0] NAL_IDR        = 5'd5;
    localparam logic [4:0] NAL_SPS        = 5'd7;
    localparam logic [4:0] NAL_SPS_EXT    = 5'd15;
    localparam logic [4:0] NAL_PPS        = 5'd8;

    // Slice QP base value and the offset of log2(MaxPicOrderCntLsb).
    localparam logic signed [7:0] QP_BASE       = 8'sd26;
    localparam logic [4:0]        LSB_LOG2_BIAS = 5'd4;

    // Width of MaxPicOrderCntLsb: 1 << (15 + 4) needs 20 bits.
    localparam int MAX_LSB_BITS = 20;

    typedef enum logic [2:0] {
        OP_OTHER,
        OP_SPS,
        OP_PPS,
        OP_SLICE,
        OP_IDR
    } op_t;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_I    = 2'd1,
        CLASS_P    = 2'd2,
        CLASS_B    = 2'd3
    } slice_class_t;

    // Item as it travels down the pipeline.
    typedef struct packed {
        op_t                op;
        slice_class_t       cls;
        logic [15:0]        lsb;
        logic [6:0]         qp_delta;
        logic [15:0]        fnum;
        logic               last_valid;
        logic [3:0]         last_log2;
    } stage_t;

    function automatic op_t decode_op(input logic [4:0] kind, input logic failed);
        op_t op;
        priority if (kind == NAL_SPS || kind == NAL_SPS_EXT) begin
            op = OP_SPS;
        end else if (kind == NAL_PPS) begin
            op = OP_PPS;
        end else if (kind == NAL_NON_IDR && !failed) begin
            op = OP_SLICE;
        end else if (kind == NAL_IDR && !failed) begin
            op = OP_IDR;
        end else begin
            op = OP_OTHER;
        end
        return op;
    endfunction

    // The slice type code modulo 5: 0 and 3 are P, 1 is B, 2 and 4 are I.
    function automatic slice_class_t class_of(input logic [3:0] skind);
        slice_class_t cls;
        unique case (skind)
            4'd0, 4'd3, 4'd5, 4'd8, 4'd10, 4'd13, 4'd15: cls = CLASS_P;
            4'd1, 4'd6, 4'd11:                           cls = CLASS_B;
            default:                                     cls = CLASS_I;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/avc_nal_slice_header_tracker.sv =====
// H.264 NAL header tracker with type-0 picture order count.
//
// The input channel (s_*) takes one parsed NAL unit header per transfer. SPS
// headers record the POC lsb width, PPS headers record their SPS id and initial
// QP offset, and parsed slices receive a picture order count, a slice QP, an
// I/P/B class and a running slice index. Every input transfer yields exactly one
// transfer on the result channel (m_*), which also carries the NAL and class
// counters.
//
// The PPS and SPS tables sit in synchronous memories. An item reads the PPS
// table at the edge that accepts it, reads the SPS table with the SPS id it
// found as it leaves stage one, and stage two resolves the POC into the
// output register. The three stages are pipelined, so the block sustains one
// item per cycle unless the receiver stalls. Table writes happen at
// acceptance, so no forwarding is needed between neighbouring items.
//
// Reset clears all table valid flags, the POC tracking state and the counters.
// When the receiver stalls, the stages fill up one by one and s_ready falls
// only once the first stage can no longer move on.
`default_nettype none

module avc_nal_slice_header_tracker #(
    parameter int PPS_ENTRIES = 256,
    parameter int SPS_ENTRIES = 32,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [4:0]         s_nal_kind,
    input  wire logic               s_parse_failed,
    input  wire logic [7:0]         s_set_id,
    input  wire logic [4:0]         s_ref_sps_id,
    input  wire logic [3:0]         s_log2_lsb_minus4,
    input  wire logic signed [5:0]  s_init_qp_offset,
    input  wire logic [3:0]         s_slice_kind,
    input  wire logic [15:0]        s_poc_lsb,
    input  wire logic signed [6:0]  s_qp_delta,
    input  wire logic [15:0]        s_frame_number,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_slice_class,
    output logic signed [31:0]      m_slice_poc,
    output logic signed [7:0]       m_slice_qp,
    output logic [15:0]             m_slice_frame_num,
    output logic [31:0]             m_slice_index,
    output logic [31:0]             m_nal_total,
    output logic [31:0]             m_i_total,
    output logic [31:0]             m_p_total,
    output logic [31:0]             m_b_total
);

    import avc_nst_pkg::*;

    localparam int PPS_AW = (PPS_ENTRIES > 1) ? $clog2(PPS_ENTRIES) : 1;
    localparam int SPS_AW = (SPS_ENTRIES > 1) ? $clog2(SPS_ENTRIES) : 1;
    // PPS entry: referenced SPS id and initial QP offset.
    localparam int PPS_DW = 11;

    // ------------------------------------------------------------------
    // Handshake and stage occupancy
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    logic   s2_valid_reg;
    logic   m_valid_reg;
    logic   s_accept;
    logic   s1_adv;
    logic   s2_adv;
    logic   s1_move;
    logic   s2_move;

    // Each stage moves on when the stage after it is empty or moving too.
    assign s2_adv   = !m_valid_reg || m_ready;
    assign s1_adv   = !s2_valid_reg || s2_adv;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign s1_move  = s1_valid_reg && s1_adv;
    assign s2_move  = s2_valid_reg && s2_adv;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    op_t                in_op;
    logic               pps_in_range;
    logic               sps_in_range;
    logic [PPS_AW-1:0]  pps_idx;
    logic [SPS_AW-1:0]  sps_widx;
    stage_t             in_item;
    logic               last_sps_valid_reg;
    logic [3:0]         last_sps_log2_reg;

    assign in_op        = decode_op(s_nal_kind, s_parse_failed);
    assign pps_in_range = int'(s_set_id) < PPS_ENTRIES;
    assign sps_in_range = int'(s_set_id) < SPS_ENTRIES;
    assign pps_idx      = s_set_id[PPS_AW-1:0];
    assign sps_widx     = s_set_id[SPS_AW-1:0];

    // The last-seen SPS is sampled before this item updates it; a slice never
    // updates it, so the slice sees every SPS that came before it.
    always_comb begin
        in_item.op         = in_op;
        in_item.lsb        = s_poc_lsb;
        in_item.qp_delta   = s_qp_delta;
        in_item.fnum       = s_frame_number;
        in_item.last_valid = last_sps_valid_reg;
        in_item.last_log2  = last_sps_log2_reg;
        unique case (in_op)
            OP_SLICE: in_item.cls = class_of(s_slice_kind);
            OP_IDR:   in_item.cls = CLASS_I;
            default:  in_item.cls = CLASS_NONE;
        endcase
    end

    // ------------------------------------------------------------------
    // PPS table: written and read when an item is accepted
    // ------------------------------------------------------------------
    logic [PPS_DW-1:0]      pps_mem [PPS_ENTRIES];
    logic [PPS_ENTRIES-1:0] pps_vld_reg;
    logic [PPS_DW-1:0]      pps_rd_reg;
    logic                   pps_hit_reg;
    logic                   pps_we;

    assign pps_we = s_accept && in_op == OP_PPS && pps_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pps_vld_reg <= '0;
        end else if (pps_we) begin
            pps_vld_reg[pps_idx] <= 1'b1;
        end
    end

    // A read in the same cycle as a write returns the old contents, which
    // is what the reading item is entitled to see.
    always_ff @(posedge aclk) begin
        if (pps_we) begin
            pps_mem[pps_idx] <= {s_ref_sps_id, s_init_qp_offset};
        end
        if (s_accept) begin
            pps_rd_reg  <= pps_mem[pps_idx];
            pps_hit_reg <= pps_in_range && pps_vld_reg[pps_idx];
        end
    end

    // ------------------------------------------------------------------
    // SPS table and last-seen SPS
    // ------------------------------------------------------------------
    logic [3:0]             sps_mem [SPS_ENTRIES];
    logic [SPS_ENTRIES-1:0] sps_vld_reg;
    logic [3:0]             sps_rd_reg;
    logic                   sps_hit_reg;
    logic                   sps_we;
    logic [4:0]             ref_sid;
    logic [SPS_AW-1:0]      sps_ridx;
    logic                   sps_rd_in_range;

    assign sps_we          = s_accept && in_op == OP_SPS && sps_in_range;
    assign ref_sid         = pps_rd_reg[PPS_DW-1 -: 5];
    assign sps_ridx        = ref_sid[SPS_AW-1:0];
    assign sps_rd_in_range = int'(ref_sid) < SPS_ENTRIES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sps_vld_reg        <= '0;
            last_sps_valid_reg <= 1'b0;
            last_sps_log2_reg  <= '0;
        end else if (s_accept && in_op == OP_SPS) begin
            last_sps_valid_reg <= 1'b1;
            last_sps_log2_reg  <= s_log2_lsb_minus4;
            if (sps_in_range) begin
                sps_vld_reg[sps_widx] <= 1'b1;
            end
        end
    end

    // The SPS read happens as the item leaves stage one; any SPS accepted in
    // that same cycle comes after the item and is not seen by it.
    always_ff @(posedge aclk) begin
        if (sps_we) begin
            sps_mem[sps_widx] <= s_log2_lsb_minus4;
        end
        if (s1_move) begin
            sps_rd_reg  <= sps_mem[sps_ridx];
            sps_hit_reg <= pps_hit_reg && sps_rd_in_range && sps_vld_reg[sps_ridx];
        end
    end

    // ------------------------------------------------------------------
    // Stage payload registers
    // ------------------------------------------------------------------
    stage_t             s1_item_reg;
    stage_t             s2_item_reg;
    logic               s2_pps_hit_reg;
    logic [5:0]         s2_qp_off_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= in_item;
        end
        if (s1_move) begin
            s2_item_reg    <= s1_item_reg;
            s2_pps_hit_reg <= pps_hit_reg;
            s2_qp_off_reg  <= pps_rd_reg[5:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage two: POC, QP and counters
    // ------------------------------------------------------------------
    logic                       use_sps;
    logic                       lsb_known;
    logic [3:0]                 log2_sel;
    logic [MAX_LSB_BITS-1:0]    max_lsb;
    logic [MAX_LSB_BITS-1:0]    half_lsb;
    logic [15:0]                lsb_down;
    logic [15:0]                lsb_up;
    logic                       wrap_fwd;
    logic                       wrap_back;
    logic                       is_slice;
    logic [31:0]                poc_val;
    logic [7:0]                 qp_val;

    logic [31:0]                poc_msb_reg;
    logic [31:0]                poc_msb_next;
    logic [15:0]                prev_lsb_reg;
    logic [15:0]                prev_lsb_next;
    logic                       poc_started_reg;
    logic                       poc_started_next;

    logic [COUNT_BITS-1:0]      nal_cnt_reg;
    logic [COUNT_BITS-1:0]      nal_cnt_next;
    logic [COUNT_BITS-1:0]      slice_cnt_reg;
    logic [COUNT_BITS-1:0]      slice_cnt_next;
    logic [COUNT_BITS-1:0]      i_cnt_reg;
    logic [COUNT_BITS-1:0]      i_cnt_next;
    logic [COUNT_BITS-1:0]      p_cnt_reg;
    logic [COUNT_BITS-1:0]      p_cnt_next;
    logic [COUNT_BITS-1:0]      b_cnt_reg;
    logic [COUNT_BITS-1:0]      b_cnt_next;

    // The SPS found through the PPS wins; otherwise the last SPS seen, and
    // with no SPS at all MaxPicOrderCntLsb is one.
    assign use_sps   = s2_pps_hit_reg && sps_hit_reg;
    assign lsb_known = use_sps || s2_item_reg.last_valid;
    assign log2_sel  = use_sps ? sps_rd_reg : s2_item_reg.last_log2;
    assign max_lsb   = lsb_known
                     ? (MAX_LSB_BITS'(1) << ({1'b0, log2_sel} + LSB_LOG2_BIAS))
                     : MAX_LSB_BITS'(1);
    assign half_lsb  = max_lsb >> 1;

    assign lsb_down  = prev_lsb_reg - s2_item_reg.lsb;
    assign lsb_up    = s2_item_reg.lsb - prev_lsb_reg;
    assign wrap_fwd  = s2_item_reg.lsb < prev_lsb_reg
                     && MAX_LSB_BITS'(lsb_down) >= half_lsb;
    assign wrap_back = s2_item_reg.lsb > prev_lsb_reg
                     && MAX_LSB_BITS'(lsb_up) > half_lsb;

    assign is_slice  = s2_item_reg.op == OP_SLICE || s2_item_reg.op == OP_IDR;

    assign qp_val = QP_BASE
                  + {s2_item_reg.qp_delta[6], s2_item_reg.qp_delta}
                  + (s2_pps_hit_reg ? {{2{s2_qp_off_reg[5]}}, s2_qp_off_reg} : 8'd0);

    always_comb begin
        poc_msb_next     = poc_msb_reg;
        prev_lsb_next    = prev_lsb_reg;
        poc_started_next = poc_started_reg;
        poc_val          = 32'hFFFF_FFFF;
        unique case (s2_item_reg.op)
            OP_IDR: begin
                poc_msb_next     = '0;
                prev_lsb_next    = '0;
                poc_started_next = 1'b1;
                poc_val          = '0;
            end
            OP_SLICE: begin
                if (poc_started_reg && wrap_fwd) begin
                    poc_msb_next = poc_msb_reg + 32'(max_lsb);
                end else if (poc_started_reg && wrap_back) begin
                    poc_msb_next = poc_msb_reg - 32'(max_lsb);
                end
                prev_lsb_next    = s2_item_reg.lsb;
                poc_started_next = 1'b1;
                poc_val          = poc_msb_next + 32'(s2_item_reg.lsb);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        nal_cnt_next   = nal_cnt_reg + COUNT_BITS'(1);
        slice_cnt_next = slice_cnt_reg;
        i_cnt_next     = i_cnt_reg;
        p_cnt_next     = p_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        if (is_slice) begin
            slice_cnt_next = slice_cnt_reg + COUNT_BITS'(1);
        end
        unique case (s2_item_reg.cls)
            CLASS_I:    i_cnt_next = i_cnt_reg + COUNT_BITS'(1);
            CLASS_P:    p_cnt_next = p_cnt_reg + COUNT_BITS'(1);
            CLASS_B:    b_cnt_next = b_cnt_reg + COUNT_BITS'(1);
            CLASS_NONE: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poc_msb_reg     <= '0;
            prev_lsb_reg    <= '0;
            poc_started_reg <= 1'b0;
            nal_cnt_reg     <= '0;
            slice_cnt_reg   <= '0;
            i_cnt_reg       <= '0;
            p_cnt_reg       <= '0;
            b_cnt_reg       <= '0;
        end else if (s2_move) begin
            poc_msb_reg     <= poc_msb_next;
            prev_lsb_reg    <= prev_lsb_next;
            poc_started_reg <= poc_started_next;
            nal_cnt_reg     <= nal_cnt_next;
            slice_cnt_reg   <= slice_cnt_next;
            i_cnt_reg       <= i_cnt_next;
            p_cnt_reg       <= p_cnt_next;
            b_cnt_reg       <= b_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [1:0]     m_class_reg;
    logic [31:0]    m_poc_reg;
    logic [7:0]     m_qp_reg;
    logic [15:0]    m_fnum_reg;
    logic [31:0]    m_index_reg;
    logic [31:0]    m_nal_reg;
    logic [31:0]    m_i_reg;
    logic [31:0]    m_p_reg;
    logic [31:0]    m_b_reg;

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            m_class_reg <= s2_item_reg.cls;
            m_poc_reg   <= poc_val;
            m_qp_reg    <= is_slice ? qp_val : 8'hFF;
            m_fnum_reg  <= is_slice ? s2_item_reg.fnum : 16'd0;
            m_index_reg <= is_slice ? 32'(slice_cnt_reg) : 32'd0;
            m_nal_reg   <= 32'(nal_cnt_next);
            m_i_reg     <= 32'(i_cnt_next);
            m_p_reg     <= 32'(p_cnt_next);
            m_b_reg     <= 32'(b_cnt_next);
        end
    end

    assign m_slice_class     = m_class_reg;
    assign m_slice_poc       = m_poc_reg;
    assign m_slice_qp        = m_qp_reg;
    assign m_slice_frame_num = m_fnum_reg;
    assign m_slice_index     = m_index_reg;
    assign m_nal_total       = m_nal_reg;
    assign m_i_total         = m_i_reg;
    assign m_p_total         = m_p_reg;
    assign m_b_total         = m_b_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avc_nst_pkg::*;

    // Clock period, reset length and the sizes of the run.
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_HEADERS = 1425;
    localparam int PPS_DEPTH      = 256;
    localparam int SPS_DEPTH      = 32;

    // The receiver holds off once, for this many cycles, after this many input
    // transfers have gone through.
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;

    // The watchdog limit is well above the long hold-off, which is the longest
    // stretch a correct block can spend without any transfer on either side.
    localparam int WATCHDOG_LIMIT = 3000;

    // Cycles allowed after the last expected result, to catch stray results.
    localparam int DRAIN_CYCLES   = 16;

    // Slice type codes; 5 to 9 mean the same classes as 0 to 4.
    localparam int SLICE_P      = 0;
    localparam int SLICE_B      = 1;
    localparam int SLICE_I      = 2;
    localparam int SLICE_SP     = 3;
    localparam int SLICE_SI     = 4;
    localparam int SLICE_P_ALL  = 5;
    localparam int SLICE_B_ALL  = 6;
    localparam int SLICE_I_ALL  = 7;
    localparam int SLICE_SP_ALL = 8;
    localparam int SLICE_SI_ALL = 9;

    // Other NAL unit types used in the directed part.
    localparam logic [4:0] NAL_UNSPECIFIED = 5'd0;
    localparam logic [4:0] NAL_SEI         = 5'd6;
    localparam logic [4:0] NAL_TOP_CODE    = 5'd31;

    typedef struct {
        logic [4:0]         nal_kind;
        logic               parse_failed;
        logic [7:0]         set_id;
        logic [4:0]         ref_sps_id;
        logic [3:0]         log2_lsb_minus4;
        logic signed [5:0]  init_qp_offset;
        logic [3:0]         slice_kind;
        logic [15:0]        poc_lsb;
        logic signed [6:0]  qp_delta;
        logic [15:0]        frame_number;
    } nal_header_t;

    typedef struct {
        slice_class_t       cls;
        logic [31:0]        poc;
        logic [7:0]         qp;
        logic [15:0]        fnum;
        logic [31:0]        idx;
        logic [31:0]        nal;
        logic [31:0]        i_cnt;
        logic [31:0]        p_cnt;
        logic [31:0]        b_cnt;
    } header_result_t;

    // Keeps its own copy of the parameter set tables and the POC tracking,
    // works out the result of every accepted header and checks the results
    // in order as they come out of the block.
    class header_tracker_board;
        logic               pps_known [PPS_DEPTH];
        logic [4:0]         pps_sps   [PPS_DEPTH];
        logic signed [5:0]  pps_qp    [PPS_DEPTH];
        logic               sps_known [SPS_DEPTH];
        logic [3:0]         sps_log2  [SPS_DEPTH];
        logic               last_known;
        logic [3:0]         last_log2;
        logic [31:0]        poc_msb;
        logic [15:0]        prev_lsb;
        logic               poc_started;
        logic [31:0]        slice_count;
        logic [31:0]        nal_count;
        logic [31:0]        i_count;
        logic [31:0]        p_count;
        logic [31:0]        b_count;
        header_result_t     expected_results [$];
        int                 errors;

        function new();
            for (int i = 0; i < PPS_DEPTH; i++) begin
                pps_known[i] = 1'b0;
                pps_sps[i]   = '0;
                pps_qp[i]    = '0;
            end
            for (int i = 0; i < SPS_DEPTH; i++) begin
                sps_known[i] = 1'b0;
                sps_log2[i]  = '0;
            end
            last_known  = 1'b0;
            last_log2   = '0;
            poc_msb     = '0;
            prev_lsb    = '0;
            poc_started = 1'b0;
            slice_count = '0;
            nal_count   = '0;
            i_count     = '0;
            p_count     = '0;
            b_count     = '0;
            errors      = 0;
        endfunction

        function void note_header(input nal_header_t h);
            header_result_t r;
            logic           found;
            logic [3:0]     found_log2;
            logic [31:0]    max_lsb;
            logic [31:0]    half;
            logic [31:0]    msb;
            logic [31:0]    lsb_w;
            logic [31:0]    prev_w;
            int             q;

            r.cls   = CLASS_NONE;
            r.poc   = '1;
            r.qp    = '1;
            r.fnum  = '0;
            r.idx   = '0;
            nal_count++;

            if (h.nal_kind == NAL_SPS || h.nal_kind == NAL_SPS_EXT) begin
                last_known = 1'b1;
                last_log2  = h.log2_lsb_minus4;
                if (int'(h.set_id) < SPS_DEPTH) begin
                    sps_known[h.set_id] = 1'b1;
                    sps_log2[h.set_id]  = h.log2_lsb_minus4;
                end
            end else if (h.nal_kind == NAL_PPS) begin
                pps_known[h.set_id] = 1'b1;
                pps_sps[h.set_id]   = h.ref_sps_id;
                pps_qp[h.set_id]    = h.init_qp_offset;
            end else if ((h.nal_kind == NAL_NON_IDR || h.nal_kind == NAL_IDR)
                         && !h.parse_failed) begin
                found      = 1'b0;
                found_log2 = '0;
                if (pps_known[h.set_id] && sps_known[pps_sps[h.set_id]]) begin
                    found      = 1'b1;
                    found_log2 = sps_log2[pps_sps[h.set_id]];
                end
                if (!found && last_known) begin
                    found      = 1'b1;
                    found_log2 = last_log2;
                end
                max_lsb = found ? (32'd1 << (int'(found_log2) + int'(LSB_LOG2_BIAS)))
                                : 32'd1;
                half    = max_lsb >> 1;

                if (h.nal_kind == NAL_IDR) begin
                    poc_msb     = '0;
                    prev_lsb    = '0;
                    poc_started = 1'b1;
                    r.poc       = '0;
                    r.cls       = CLASS_I;
                end else begin
                    msb    = poc_msb;
                    lsb_w  = {16'd0, h.poc_lsb};
                    prev_w = {16'd0, prev_lsb};
                    if (poc_started) begin
                        if (lsb_w < prev_w && (prev_w - lsb_w) >= half) begin
                            msb = msb + max_lsb;
                        end else if (lsb_w > prev_w && (lsb_w - prev_w) > half) begin
                            msb = msb - max_lsb;
                        end
                    end
                    r.poc       = msb + lsb_w;
                    poc_msb     = msb;
                    prev_lsb    = h.poc_lsb;
                    poc_started = 1'b1;
                    case (int'(h.slice_kind) % 5)
                        SLICE_I, SLICE_SI: r.cls = CLASS_I;
                        SLICE_P, SLICE_SP: r.cls = CLASS_P;
                        default:           r.cls = CLASS_B;
                    endcase
                end

                q = int'(QP_BASE) + int'(h.qp_delta);
                if (pps_known[h.set_id]) begin
                    q = q + int'(pps_qp[h.set_id]);
                end
                r.qp   = q[7:0];
                r.fnum = h.frame_number;
                r.idx  = slice_count;
                slice_count++;
                case (r.cls)
                    CLASS_I: i_count++;
                    CLASS_P: p_count++;
                    default: b_count++;
                endcase
            end

            r.nal   = nal_count;
            r.i_cnt = i_count;
            r.p_cnt = p_count;
            r.b_cnt = b_count;
            expected_results = {expected_results, r};
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(input header_result_t got);
            header_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $error("result transfer with no header waiting for it");
                return;
            end
            want = expected_results.pop_front();
            compare_field("slice_class",     32'(want.cls), 32'(got.cls));
            compare_field("slice_poc",       want.poc,      got.poc);
            compare_field("slice_qp",        32'(want.qp),  32'(got.qp));
            compare_field("slice_frame_num", 32'(want.fnum), 32'(got.fnum));
            compare_field("slice_index",     want.idx,      got.idx);
            compare_field("nal_total",       want.nal,      got.nal);
            compare_field("i_total",         want.i_cnt,    got.i_cnt);
            compare_field("p_total",         want.p_cnt,    got.p_cnt);
            compare_field("b_total",         want.b_cnt,    got.b_cnt);
        endfunction
    endclass

    // Clock, reset and every input of the block start at known values.
    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [4:0]         s_nal_kind        = '0;
    logic               s_parse_failed    = 1'b0;
    logic [7:0]         s_set_id          = '0;
    logic [4:0]         s_ref_sps_id      = '0;
    logic [3:0]         s_log2_lsb_minus4 = '0;
    logic signed [5:0]  s_init_qp_offset  = '0;
    logic [3:0]         s_slice_kind      = '0;
    logic [15:0]        s_poc_lsb         = '0;
    logic signed [6:0]  s_qp_delta        = '0;
    logic [15:0]        s_frame_number    = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [1:0]         m_slice_class;
    logic signed [31:0] m_slice_poc;
    logic signed [7:0]  m_slice_qp;
    logic [15:0]        m_slice_frame_num;
    logic [31:0]        m_slice_index;
    logic [31:0]        m_nal_total;
    logic [31:0]        m_i_total;
    logic [31:0]        m_p_total;
    logic [31:0]        m_b_total;

    header_tracker_board board;

    // Number of input transfers so far; the receiver uses it to time its
    // long hold-off.
    int headers_accepted = 0;

    // State of the random stream: the lsb width of the last SPS sent and the
    // lsb of the last slice, so that most slices step on plausibly from the
    // one before and the wrap tracking is exercised in earnest.
    int gen_log2 = 0;
    int gen_lsb  = 0;

    avc_nal_slice_header_tracker dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_nal_kind        (s_nal_kind),
        .s_parse_failed    (s_parse_failed),
        .s_set_id          (s_set_id),
        .s_ref_sps_id      (s_ref_sps_id),
        .s_log2_lsb_minus4 (s_log2_lsb_minus4),
        .s_init_qp_offset  (s_init_qp_offset),
        .s_slice_kind      (s_slice_kind),
        .s_poc_lsb         (s_poc_lsb),
        .s_qp_delta        (s_qp_delta),
        .s_frame_number    (s_frame_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_slice_class     (m_slice_class),
        .m_slice_poc       (m_slice_poc),
        .m_slice_qp        (m_slice_qp),
        .m_slice_frame_num (m_slice_frame_num),
        .m_slice_index     (m_slice_index),
        .m_nal_total       (m_nal_total),
        .m_i_total         (m_i_total),
        .m_p_total         (m_p_total),
        .m_b_total         (m_b_total)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Builds one header from plain integers; signed fields keep their low bits.
    function automatic nal_header_t header_of(input logic [4:0] kind, input int failed,
                                              input int sid, input int ref_sps,
                                              input int log2m4, input int qp_off,
                                              input int skind, input int lsb,
                                              input int qpd, input int fnum);
        nal_header_t h;
        h.nal_kind        = kind;
        h.parse_failed    = failed[0];
        h.set_id          = sid[7:0];
        h.ref_sps_id      = ref_sps[4:0];
        h.log2_lsb_minus4 = log2m4[3:0];
        h.init_qp_offset  = qp_off[5:0];
        h.slice_kind      = skind[3:0];
        h.poc_lsb         = lsb[15:0];
        h.qp_delta        = qpd[6:0];
        h.frame_number    = fnum[15:0];
        return h;
    endfunction

    // One random header. Every field starts random so that each bit
    // toggles; most headers are then shaped into a well-formed stream of
    // parameter sets and slices over a handful of ids, and the rest are left
    // as noise, failed slices or lookups of ids that were never written.
    function automatic nal_header_t random_header();
        nal_header_t h;
        int          pick;
        int          sel;
        int          max_lsb;
        int          half;
        int          stride;

        h.nal_kind        = 5'($urandom_range(0, 31));
        h.parse_failed    = 1'($urandom_range(0, 1));
        h.set_id          = 8'($urandom_range(0, 255));
        h.ref_sps_id      = 5'($urandom_range(0, 31));
        h.log2_lsb_minus4 = 4'($urandom_range(0, 12));
        h.init_qp_offset  = 6'($urandom_range(0, 63));
        h.slice_kind      = 4'($urandom_range(0, 9));
        h.poc_lsb         = 16'($urandom_range(0, 65535));
        h.qp_delta        = 7'($urandom_range(0, 127));
        h.frame_number    = 16'($urandom_range(0, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            h.nal_kind = ($urandom_range(0, 3) == 0) ? NAL_SPS_EXT : NAL_SPS;
            if ($urandom_range(0, 7) != 0) begin
                h.set_id = 8'($urandom_range(0, 7));
            end
            // Narrow lsb fields wrap often; the widest still turn up.
            if ($urandom_range(0, 2) != 0) begin
                h.log2_lsb_minus4 = 4'($urandom_range(0, 3));
            end
            gen_log2 = int'(h.log2_lsb_minus4);
            gen_lsb  = gen_lsb % (1 << (gen_log2 + 4));
        end else if (pick < 12) begin
            h.nal_kind = NAL_PPS;
            if ($urandom_range(0, 7) != 0) begin
                h.set_id = 8'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 3) != 0) begin
                h.ref_sps_id = 5'($urandom_range(0, 7));
            end
        end else if (pick < 16) begin
            h.nal_kind     = NAL_IDR;
            h.parse_failed = 1'b0;
            if ($urandom_range(0, 7) != 0) begin
                h.set_id = 8'($urandom_range(0, 7));
            end
            gen_lsb = 0;
        end else if (pick < 82) begin
            h.nal_kind     = NAL_NON_IDR;
            h.parse_failed = 1'b0;
            if ($urandom_range(0, 15) != 0) begin
                h.set_id = 8'($urandom_range(0, 7));
            end
            max_lsb = 1 << (gen_log2 + 4);
            half    = max_lsb / 2;
            sel     = $urandom_range(0, 19);
            // Mostly small steps forward, some back, and steps right on
            // either side of half the lsb range, where the wrap decision flips.
            if (sel <= 10) begin
                stride = $urandom_range(1, 3);
            end else if (sel <= 13) begin
                stride = -$urandom_range(1, 3);
            end else if (sel == 14) begin
                stride = half;
            end else if (sel == 15) begin
                stride = -half;
            end else if (sel == 16) begin
                stride = half + 1;
            end else if (sel == 17) begin
                stride = -(half + 1);
            end else begin
                stride = 0;
            end
            if (sel != 19) begin
                gen_lsb   = ((gen_lsb + stride) % max_lsb + max_lsb) % max_lsb;
                h.poc_lsb = 16'(gen_lsb);
            end
        end else if (pick < 90) begin
            h.nal_kind     = ($urandom_range(0, 1) == 0) ? NAL_NON_IDR : NAL_IDR;
            h.parse_failed = 1'b1;
        end

        return h;
    endfunction

    // Offers one header and returns once it has been transferred. Valid and
    // the payload are set with nonblocking assignments right after an edge,
    // and the handshake is judged on the values seen at the following edges.
    task automatic send_header(input nal_header_t h);
        s_valid           <= 1'b1;
        s_nal_kind        <= h.nal_kind;
        s_parse_failed    <= h.parse_failed;
        s_set_id          <= h.set_id;
        s_ref_sps_id      <= h.ref_sps_id;
        s_log2_lsb_minus4 <= h.log2_lsb_minus4;
        s_init_qp_offset  <= h.init_qp_offset;
        s_slice_kind      <= h.slice_kind;
        s_poc_lsb         <= h.poc_lsb;
        s_qp_delta        <= h.qp_delta;
        s_frame_number    <= h.frame_number;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Monitors for both channels. An input transfer is handed to the
    // predictor and a result transfer to the checker, both on the values
    // that stood just before the edge.
    always @(posedge aclk) begin
        nal_header_t    seen_header;
        header_result_t seen_result;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen_header.nal_kind        = s_nal_kind;
                seen_header.parse_failed    = s_parse_failed;
                seen_header.set_id          = s_set_id;
                seen_header.ref_sps_id      = s_ref_sps_id;
                seen_header.log2_lsb_minus4 = s_log2_lsb_minus4;
                seen_header.init_qp_offset  = s_init_qp_offset;
                seen_header.slice_kind      = s_slice_kind;
                seen_header.poc_lsb         = s_poc_lsb;
                seen_header.qp_delta        = s_qp_delta;
                seen_header.frame_number    = s_frame_number;
                board.note_header(seen_header);
                headers_accepted++;
            end
            if (m_valid && m_ready) begin
                seen_result.cls   = slice_class_t'(m_slice_class);
                seen_result.poc   = m_slice_poc;
                seen_result.qp    = m_slice_qp;
                seen_result.fnum  = m_slice_frame_num;
                seen_result.idx   = m_slice_index;
                seen_result.nal   = m_nal_total;
                seen_result.i_cnt = m_i_total;
                seen_result.p_cnt = m_p_total;
                seen_result.b_cnt = m_b_total;
                board.check_result(seen_result);
            end
        end
    end

    // Receiver. It moves through segments of random length, each with its
    // own stall pattern: always ready, mostly ready, mostly stalled, or a
    // fixed one-in-three stall. Once, part way through the run, it holds off
    // for a long stretch while the sender keeps offering headers, so that the
    // pipeline fills and the block has to push back on its input.
    initial begin : receiver
        bit hold_done;
        int mode;
        int seg_len;
        int tick;
        hold_done = 1'b0;
        tick      = 0;
        wait (aresetn);
        forever begin
            if (!hold_done && headers_accepted >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 60);
                repeat (seg_len) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 3) != 0);
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= (tick % 3 != 0);
                    endcase
                    tick++;
                    @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel makes a transfer.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (aresetn);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus. The directed headers come first, then the random stream; the
    // sender works in bursts with random gaps between them.
    initial begin : stimulus
        nal_header_t directed [$];
        nal_header_t hdr;
        int          total;
        int          burst_left;
        int          gap;

        board = new();

        // Slices before any SPS: the lsb range is one, so every change of
        // lsb moves the msb by one in the opposite direction.
        directed = {directed, header_of(NAL_NON_IDR, 0, 0, 0, 0, 0, SLICE_P, 100, 0, 0)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 0, 0, 0, 0, SLICE_B, 50, 5, 1)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 0, 0, 0, 0, SLICE_I, 60, -5, 2)};
        // Failed parses are only counted.
        directed = {directed, header_of(NAL_NON_IDR, 1, 0, 0, 0, 0, SLICE_P, 7, 0, 3)};
        directed = {directed, header_of(NAL_IDR, 1, 0, 0, 0, 0, SLICE_I, 7, 0, 4)};
        // Other NAL types, the first two with every other field at its top value.
        directed = {directed, header_of(NAL_UNSPECIFIED, 1, 255, 31, 12, -1, 9, 65535,
                                        -1, 65535)};
        directed = {directed, header_of(NAL_TOP_CODE, 1, 255, 31, 12, -1, 9, 65535, -1,
                                        65535)};
        directed = {directed, header_of(NAL_SEI, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        // An SPS with the narrowest lsb field, then a subset SPS whose id is
        // just past the table: it is not stored but becomes the last SPS.
        directed = {directed, header_of(NAL_SPS, 0, 3, 0, 0, 0, 0, 0, 0, 0)};
        directed = {directed, header_of(NAL_SPS_EXT, 0, SPS_DEPTH, 0, 12, 0, 0, 0, 0, 0)};
        // One PPS on a known SPS with the lowest offset, one on an unknown SPS
        // with the highest.
        directed = {directed, header_of(NAL_PPS, 0, 255, 3, 0, -32, 0, 0, 0, 0)};
        directed = {directed, header_of(NAL_PPS, 0, 0, 31, 0, 31, 0, 0, 0, 0)};
        // IDR clears the tracking; the highest delta meets the lowest offset.
        directed = {directed, header_of(NAL_IDR, 0, 255, 0, 0, 0, SLICE_P, 1234, 63, 0)};
        // Through PPS 255 the lsb range is 16: wrap down, wrap back up, then
        // steps of exactly half the range in each direction.
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_P, 14, 0, 10)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_P, 2, 0, 11)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_P, 10, 0, 12)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_P, 2, 0, 13)};
        // PPS 0 points at a missing SPS, so the last SPS (range 65536) is used;
        // the lowest delta, the top lsb and the top frame number.
        directed = {directed, header_of(NAL_NON_IDR, 0, 0, 0, 0, 0, SLICE_B, 65535, -64,
                                        65535)};
        // A PPS id that was never written falls back to the last SPS too.
        directed = {directed, header_of(NAL_NON_IDR, 0, 100, 0, 0, 0, SLICE_SP, 0, 0, 0)};
        // The remaining slice types.
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_SI, 1, 1, 20)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_P_ALL, 3, 2,
                                        21)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_B_ALL, 5, 3,
                                        22)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_I_ALL, 7, 4,
                                        23)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_SP_ALL, 9, 5,
                                        24)};
        directed = {directed, header_of(NAL_NON_IDR, 0, 255, 0, 0, 0, SLICE_SI_ALL, 11, 6,
                                        25)};

        total = directed.size() + RANDOM_HEADERS;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < total; n++) begin
            hdr = (n < directed.size()) ? directed[n] : random_header();
            send_header(hdr);
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                // Now and then a long burst with no idling at all.
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                         : $urandom_range(1, 24);
            end
        end
        s_valid <= 1'b0;

        // Wait for every expected result, then a little longer so that a
        // stray extra result would still be caught.
        while (board.expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/avc_nst_pkg.sv
rtl/core/avc_nal_slice_header_tracker.sv
verif/tb.sv
